[rtl/led_pixel_effect_color_defines.svh]
// Assertion macros used by the checker file
`ifndef LED_PIXEL_EFFECT_COLOR_DEFINES_SVH
`define LED_PIXEL_EFFECT_COLOR_DEFINES_SVH

// Same-cycle implication, held off during reset
`define LPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define LPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lpe_pkg.sv]
// Shared types, constants and arithmetic helpers for the pixel effect pipeline
package lpe_pkg;

    localparam int PIXEL_COUNT     = 256;
    localparam int SINE_TABLE_SIZE = 256;
    localparam int SINE_IDX_W      = $clog2(SINE_TABLE_SIZE);
    localparam int SINE_HALF       = SINE_TABLE_SIZE / 2;

    // Phase steps in Q24 turns
    localparam logic [23:0] STEP_FRAME_FAST = 24'd133509;
    localparam logic [23:0] STEP_POS_WAVE   = 24'd1068071;
    localparam logic [23:0] STEP_FRAME_SLOW = 24'd80105;

    // Register indexes
    localparam logic [2:0] REG_BRIGHTNESS = 3'd0;
    localparam logic [2:0] REG_IDLE_FX    = 3'd1;
    localparam logic [2:0] REG_CURSOR_FX  = 3'd2;
    localparam logic [2:0] REG_PRESET_R   = 3'd3;
    localparam logic [2:0] REG_PRESET_G   = 3'd4;
    localparam logic [2:0] REG_PRESET_B   = 3'd5;

    // Idle effect codes
    localparam logic [2:0] IDLE_RAINBOW  = 3'd1;
    localparam logic [2:0] IDLE_WARM     = 3'd2;
    localparam logic [2:0] IDLE_BREATHE  = 3'd3;
    localparam logic [2:0] IDLE_SLOW_RBW = 3'd4;

    // Cursor effect codes
    localparam logic [1:0] CUR_STEADY  = 2'd0;
    localparam logic [1:0] CUR_BLINK   = 2'd1;
    localparam logic [1:0] CUR_BREATHE = 2'd2;
    localparam logic [1:0] CUR_HUE     = 2'd3;

    typedef enum logic [1:0] {DIV_NONE, DIV_BY_255, DIV_BY_10} div_sel_t;
    typedef enum logic [1:0] {FAC_1, FAC_2, FAC_6} fac_t;

    // Operands and divider plan for one colour channel lane
    typedef struct packed {
        logic [7:0]  a;
        logic [15:0] b;
        logic [3:0]  z;
        div_sel_t    d5;
        div_sel_t    d6;
        fac_t        f;
    } lane_op_t;

    typedef logic [SINE_TABLE_SIZE-1:0][7:0] sine_tab_t;

    // Unsigned long division, used only while building tables
    function automatic int udiv(input int num, input int den);
        logic [31:0] q;
        logic [32:0] r;
        q = '0;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            r = {r[31:0], num[i]};
            if (r >= 33'(den))
            begin
                r    = r - 33'(den);
                q[i] = 1'b1;
            end
        end
        return int'(q);
    endfunction

    // Build the sine table at elaboration
    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        int n;
        int u;
        int a;
        int d;
        n = SINE_HALF;
        for (int k = 0; k < SINE_TABLE_SIZE; k++)
        begin
            // Fold the index into one half-turn
            u = k;
            if (u >= n) u = u - n;
            if (u >= n) u = u - n;
            a = u * (n - u);
            d = 5 * n * n - 4 * a;
            if (k < n)
                tab[k] = 8'(128 + udiv(127 * 16 * a, d));
            else
                tab[k] = 8'(128 - udiv(128 * 16 * a, d));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    // floor(x/10), exact below 16384
    function automatic logic [10:0] div10(input logic [13:0] x);
        logic [29:0] prod;
        prod = 30'(x) * 30'd6554;
        return prod[26:16];
    endfunction

endpackage

[rtl/lpe_front.sv]
// Front end: mode decode, phase and hue, then sine lookup and lane operands
module lpe_front (
    input  logic                   clk,
    input  logic                   en,
    input  logic                   in_take,
    input  logic [15:0]            frame_count,
    input  logic [7:0]             pixel_position,
    input  logic                   is_cursor,
    input  logic                   idle_active,
    input  logic                   led_on,
    input  logic [7:0]             led_red,
    input  logic [7:0]             led_green,
    input  logic [7:0]             led_blue,
    input  logic [3:0]             brightness_level,
    input  logic [2:0]             idle_effect,
    input  logic [1:0]             cursor_effect,
    input  logic [7:0]             preset_red,
    input  logic [7:0]             preset_green,
    input  logic [7:0]             preset_blue,
    output lpe_pkg::lane_op_t [2:0] op
);
    import lpe_pkg::*;

    typedef enum logic [2:0] {MODE_BLACK, MODE_SCALED, MODE_HSV, MODE_BREATHE, MODE_WARM}
        mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic [3:0]            level;
        logic [7:0]            hue;
        logic [7:0]            sat;
        logic [SINE_IDX_W-1:0] sidx;
        logic [2:0][7:0]       col;
    } s1_t;

    s1_t                    s1_next;
    s1_t                    s1_reg;
    lane_op_t [2:0]         op_next;
    lane_op_t [2:0]         op_reg;

    logic [33:0]            blink_prod;
    logic [39:0]            fast_prod;
    logic [31:0]            pos_prod;
    logic [39:0]            slow_prod;
    logic [23:0]            ph_fast;
    logic [23:0]            ph_warm;
    logic [23:0]            ph_slow;
    logic [23:0]            phase;
    logic [47:0]            idx_prod;
    logic                   idle_fx;

    // Stage 1: decode the effect, hue and sine phase
    always_comb
    begin
        blink_prod = 34'(frame_count) * 34'd69906;
        fast_prod  = 40'(frame_count) * 40'(STEP_FRAME_FAST);
        pos_prod   = 32'(pixel_position) * 32'(STEP_POS_WAVE);
        slow_prod  = 40'(frame_count) * 40'(STEP_FRAME_SLOW);
        ph_fast    = fast_prod[23:0];
        ph_warm    = ph_fast + pos_prod[23:0];
        ph_slow    = slow_prod[23:0];
        idle_fx    = idle_active && (idle_effect inside {[IDLE_RAINBOW:IDLE_SLOW_RBW]});
        phase      = ph_fast;

        s1_next.level = (brightness_level > 4'd10) ? 4'd10 : brightness_level;
        s1_next.hue   = 8'd0;
        s1_next.sat   = 8'd255;
        s1_next.col   = {preset_blue, preset_green, preset_red};
        s1_next.mode  = MODE_BLACK;

        if ({1'b0, pixel_position} >= 9'(PIXEL_COUNT))
        begin
            s1_next.mode = MODE_BLACK;
        end
        else if (is_cursor)
        begin
            case (cursor_effect)
                CUR_STEADY:  s1_next.mode = MODE_SCALED;
                CUR_BLINK:   s1_next.mode = blink_prod[20] ? MODE_BLACK : MODE_SCALED;
                CUR_BREATHE: s1_next.mode = MODE_BREATHE;
                CUR_HUE:
                begin
                    s1_next.mode = MODE_HSV;
                    s1_next.hue  = 8'(10'(frame_count[7:0]) * 10'd3);
                end
                default:     s1_next.mode = MODE_BLACK;
            endcase
        end
        else if (idle_fx)
        begin
            case (idle_effect)
                IDLE_RAINBOW:
                begin
                    s1_next.mode = MODE_HSV;
                    s1_next.hue  = frame_count[7:0] + {pixel_position[4:0], 3'b000};
                end
                IDLE_WARM:
                begin
                    s1_next.mode = MODE_WARM;
                    phase        = ph_warm;
                end
                IDLE_BREATHE:
                begin
                    s1_next.mode = MODE_BREATHE;
                    phase        = ph_slow;
                end
                default:
                begin
                    s1_next.mode = MODE_HSV;
                    s1_next.sat  = 8'd200;
                    s1_next.hue  = {frame_count[6:0], 1'b0}
                                 + 8'(11'(pixel_position) * 11'd6);
                end
            endcase
        end
        else if (led_on)
        begin
            s1_next.mode = MODE_SCALED;
            s1_next.col  = {led_blue, led_green, led_red};
        end

        idx_prod     = 48'(phase) * 48'(SINE_TABLE_SIZE);
        s1_next.sidx = idx_prod[24 +: SINE_IDX_W];
    end

    // Hold stage 1 on stall
    always_ff @(posedge clk)
    begin
        if (en && in_take)
        begin
            s1_reg <= s1_next;
        end
        else if (en)
        begin
            s1_reg.mode <= MODE_BLACK;
        end
    end

    logic [7:0]  w;
    logic [10:0] h6;
    logic [2:0]  sext;
    logic [10:0] base;
    logic [7:0]  rem;
    logic [7:0]  ps;
    logic [15:0] kp;
    logic [15:0] kq;
    logic [15:0] kt;
    logic [15:0] sr;
    logic [15:0] st;
    logic [11:0] vm_n;
    logic [7:0]  vmax;
    logic [2:0][15:0] kch;

    // Stage 2: sine lookup, sextant split and lane operand select
    always_comb
    begin
        w  = SINE_TAB[s1_reg.sidx];
        h6 = 11'(s1_reg.hue) * 11'd6;
        if (h6 >= 11'd1530)      begin sext = 3'd6; base = 11'd1530; end
        else if (h6 >= 11'd1275) begin sext = 3'd5; base = 11'd1275; end
        else if (h6 >= 11'd1020) begin sext = 3'd4; base = 11'd1020; end
        else if (h6 >= 11'd765)  begin sext = 3'd3; base = 11'd765;  end
        else if (h6 >= 11'd510)  begin sext = 3'd2; base = 11'd510;  end
        else if (h6 >= 11'd255)  begin sext = 3'd1; base = 11'd255;  end
        else                     begin sext = 3'd0; base = 11'd0;    end
        rem  = 8'(h6 - base);
        ps   = 8'd255 - s1_reg.sat;
        kp   = 16'(ps) * 16'd255;
        sr   = 16'(s1_reg.sat) * 16'(rem);
        st   = 16'(s1_reg.sat) * 16'(8'd255 - rem);
        kq   = 16'd65025 - sr;
        kt   = 16'd65025 - st;
        vm_n = 12'(s1_reg.level) * 12'd255;
        vmax = 8'(div10(14'(vm_n)));

        case (sext)
            3'd1:    kch = {kp, 16'd65025, kq};
            3'd2:    kch = {kt, 16'd65025, kp};
            3'd3:    kch = {16'd65025, kq, kp};
            3'd4:    kch = {16'd65025, kp, kt};
            3'd5:    kch = {kq, kp, 16'd65025};
            default: kch = {kp, kt, 16'd65025};
        endcase

        for (int c = 0; c < 3; c++)
        begin
            op_next[c].a  = 8'd0;
            op_next[c].b  = 16'd0;
            op_next[c].z  = 4'd1;
            op_next[c].d5 = DIV_NONE;
            op_next[c].d6 = DIV_NONE;
            op_next[c].f  = FAC_1;
            case (s1_reg.mode)
                MODE_SCALED:
                begin
                    op_next[c].a  = s1_reg.col[c];
                    op_next[c].b  = 16'(s1_reg.level);
                    op_next[c].d6 = DIV_BY_10;
                end
                MODE_HSV:
                begin
                    op_next[c].a  = vmax;
                    op_next[c].b  = kch[c];
                    op_next[c].d5 = DIV_BY_255;
                    op_next[c].d6 = DIV_BY_255;
                end
                MODE_BREATHE:
                begin
                    op_next[c].a  = s1_reg.col[c];
                    op_next[c].b  = 16'(w);
                    op_next[c].z  = s1_reg.level;
                    op_next[c].d5 = DIV_BY_255;
                    op_next[c].d6 = DIV_BY_10;
                end
                MODE_WARM:
                begin
                    op_next[c].a  = w;
                    op_next[c].b  = 16'(s1_reg.level);
                    op_next[c].d5 = DIV_BY_10;
                    op_next[c].d6 = (c == 0) ? DIV_NONE : DIV_BY_10;
                    op_next[c].f  = (c == 0) ? FAC_1 : ((c == 1) ? FAC_6 : FAC_2);
                end
                default:
                begin
                    op_next[c].a = 8'd0;
                end
            endcase
        end
    end

    // Hold stage 2 on stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg <= op_next;
        end
    end

    assign op = op_reg;

endmodule

[rtl/lpe_lane.sv]
// One colour channel: two multiplies then two constant divides, one per stage
module lpe_lane (
    input  logic              clk,
    input  logic              en,
    input  lpe_pkg::lane_op_t op,
    output logic [7:0]        result
);
    import lpe_pkg::*;

    logic [23:0] p3_reg;
    logic [3:0]  z3_reg;
    div_sel_t    d53_reg;
    div_sel_t    d63_reg;
    fac_t        f3_reg;
    logic [23:0] p4_reg;
    div_sel_t    d54_reg;
    div_sel_t    d64_reg;
    fac_t        f4_reg;
    logic [15:0] p5_reg;
    div_sel_t    d65_reg;
    fac_t        f5_reg;
    logic [7:0]  res_reg;

    logic [15:0] p5_next;
    logic [47:0] m255_wide;
    logic [15:0] fx;
    logic [32:0] m255_narrow;
    logic [7:0]  res_next;

    // Stage 3 and 4: product, then scale by z (the level in breathe mode, else one)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_reg  <= 24'(op.a) * 24'(op.b);
            z3_reg  <= op.z;
            d53_reg <= op.d5;
            d63_reg <= op.d6;
            f3_reg  <= op.f;
            p4_reg  <= 24'(p3_reg * 24'(z3_reg));
            d54_reg <= d53_reg;
            d64_reg <= d63_reg;
            f4_reg  <= f3_reg;
        end
    end

    // Stage 5: first constant divide
    always_comb
    begin
        m255_wide = 48'(p4_reg) * 48'd8421505;
        case (d54_reg)
            DIV_BY_255: p5_next = m255_wide[46:31];
            DIV_BY_10:  p5_next = 16'(div10(p4_reg[13:0]));
            default:    p5_next = p4_reg[15:0];
        endcase
    end

    // Stage 6: pre-factor, then second constant divide
    always_comb
    begin
        case (f5_reg)
            FAC_2:   fx = {p5_reg[14:0], 1'b0};
            FAC_6:   fx = {p5_reg[13:0], 2'b00} + {p5_reg[14:0], 1'b0};
            default: fx = p5_reg;
        endcase
        m255_narrow = 33'(fx) * 33'd65794;
        case (d65_reg)
            DIV_BY_255: res_next = m255_narrow[31:24];
            DIV_BY_10:  res_next = 8'(div10(fx[13:0]));
            default:    res_next = fx[7:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_reg  <= p5_next;
            d65_reg <= d64_reg;
            f5_reg  <= f4_reg;
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

[rtl/led_pixel_effect_color.sv]
// Pixel colour effect pipeline, top level.
// An accepted input beat moves through front stages 1 and 2, then lane stages 3 to 6.
// Throughput: one pixel per cycle; the whole pipe advances while the output
// register is empty or being taken, so a stalled output holds every stage.
// Reset clears the stage valid bits and loads the register defaults
// (brightness 5, effects off, preset white).
module led_pixel_effect_color (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] frame_count,
    input  logic [7:0]  pixel_position,
    input  logic        is_cursor,
    input  logic        idle_active,
    input  logic        led_on,
    input  logic [7:0]  led_red,
    input  logic [7:0]  led_green,
    input  logic [7:0]  led_blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import lpe_pkg::*;

    logic [3:0] brightness_reg;
    logic [2:0] idle_fx_reg;
    logic [1:0] cursor_fx_reg;
    logic [7:0] preset_r_reg;
    logic [7:0] preset_g_reg;
    logic [7:0] preset_b_reg;
    logic [5:0] valid_reg;
    logic [5:0] valid_next;
    logic       en;
    lane_op_t [2:0] op;
    logic [2:0][7:0] res;

    assign cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= 4'd5;
            idle_fx_reg    <= 3'd0;
            cursor_fx_reg  <= CUR_STEADY;
            preset_r_reg   <= 8'd255;
            preset_g_reg   <= 8'd255;
            preset_b_reg   <= 8'd255;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BRIGHTNESS: brightness_reg <= cfg_data[3:0];
                REG_IDLE_FX:    idle_fx_reg    <= cfg_data[2:0];
                REG_CURSOR_FX:  cursor_fx_reg  <= cfg_data[1:0];
                REG_PRESET_R:   preset_r_reg   <= cfg_data;
                REG_PRESET_G:   preset_g_reg   <= cfg_data;
                REG_PRESET_B:   preset_b_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Advance the whole pipe unless the output beat is stalled
    assign en         = !valid_reg[5] || out_ready;
    assign in_ready   = en;
    assign valid_next = {valid_reg[4:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 6'd0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    lpe_front u_front (
        .clk              (clk),
        .en               (en),
        .in_take          (in_valid),
        .frame_count      (frame_count),
        .pixel_position   (pixel_position),
        .is_cursor        (is_cursor),
        .idle_active      (idle_active),
        .led_on           (led_on),
        .led_red          (led_red),
        .led_green        (led_green),
        .led_blue         (led_blue),
        .brightness_level (brightness_reg),
        .idle_effect      (idle_fx_reg),
        .cursor_effect    (cursor_fx_reg),
        .preset_red       (preset_r_reg),
        .preset_green     (preset_g_reg),
        .preset_blue      (preset_b_reg),
        .op               (op)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        lpe_lane u_lane (
            .clk    (clk),
            .en     (en),
            .op     (op[c]),
            .result (res[c])
        );
    end

    assign out_valid = valid_reg[5];
    assign out_red   = res[0];
    assign out_green = res[1];
    assign out_blue  = res[2];

endmodule

[rtl/lpe_checker.sv]
// Port-level checks on the pixel effect pipeline, bound to the top level
`include "led_pixel_effect_color_defines.svh"

module lpe_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic       cfg_valid,
    input logic       cfg_ready
);
    // A stalled output beat holds
    `LPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue), "output beat changed while stalled")
    // The input side opens whenever the output side can move
    `LPE_ASSERT_NOW(a_in_open, !out_valid || out_ready, in_ready, "input blocked with room in the pipe")
    // A stalled output blocks new input beats
    `LPE_ASSERT_NOW(a_in_stall, out_valid && !out_ready, !in_ready, "input taken while output stalled")
    // Register writes never wait
    `LPE_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "register write refused")

endmodule

bind led_pixel_effect_color lpe_checker u_lpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

[verif/led_pixel_effect_color_test.sv]
// Self-checking testbench for the pixel colour effect pipeline
module led_pixel_effect_color_test;
    import lpe_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] frame_count;
    logic [7:0]  pixel_position;
    logic        is_cursor;
    logic        idle_active;
    logic        led_on;
    logic [7:0]  led_red;
    logic [7:0]  led_green;
    logic [7:0]  led_blue;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;

    typedef struct packed {
        logic [15:0] frame;
        logic [7:0]  pos;
        logic        cur;
        logic        idle;
        logic        on;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
    } pixel_req_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Directed row: request plus optional hand-typed colour
    typedef struct packed {
        pixel_req_t req;
        logic       known;
        rgb_t       rgb;
    } pixel_row_t;

    // Shadow registers
    logic [3:0] sh_bright;
    logic [2:0] sh_idle_fx;
    logic [1:0] sh_cursor_fx;
    logic [7:0] sh_pr, sh_pg, sh_pb;

    rgb_t       colour_queue[$];
    int         errors;
    longint     cycles;
    bit         stim_done;
    bit         hold_off_req;
    bit         burst_mode;
    logic [7:0] wave_tab[256];

    led_pixel_effect_color dut (.*);

    always #5 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int bright_level();
        return (sh_bright > 10) ? 10 : int'(sh_bright);
    endfunction

    function automatic rgb_t hsv_colour(int h, int s, int v);
        int i, rm, p, q, t;
        rgb_t c;
        i = (h * 6) / 255;
        rm = h * 6 - i * 255;
        if (i >= 6) i = 0;
        p = v * (255 - s) / 255;
        q = v * (65025 - s * rm) / 65025;
        t = v * (65025 - s * (255 - rm)) / 65025;
        case (i)
            0: c = '{v[7:0], t[7:0], p[7:0]};
            1: c = '{q[7:0], v[7:0], p[7:0]};
            2: c = '{p[7:0], v[7:0], t[7:0]};
            3: c = '{p[7:0], q[7:0], v[7:0]};
            4: c = '{t[7:0], p[7:0], v[7:0]};
            default: c = '{v[7:0], p[7:0], q[7:0]};
        endcase
        return c;
    endfunction

    function automatic int wave_at(longint ph);
        return wave_tab[((ph & 64'hFFFFFF) * 256) >> 24];
    endfunction

    function automatic rgb_t dim(int r, int g, int b);
        int l;
        rgb_t c;
        l = bright_level();
        c.r = 8'(r * l / 10);
        c.g = 8'(g * l / 10);
        c.b = 8'(b * l / 10);
        return c;
    endfunction

    function automatic rgb_t breathe_colour(int w);
        int l;
        rgb_t c;
        l = bright_level();
        c.r = 8'(sh_pr * w * l / 2550);
        c.g = 8'(sh_pg * w * l / 2550);
        c.b = 8'(sh_pb * w * l / 2550);
        return c;
    endfunction

    // Expected drive colour of one pixel request
    function automatic rgb_t pixel_colour(pixel_req_t q);
        longint f, p;
        int l, vmax, w, v;
        rgb_t c;
        f = q.frame;
        p = q.pos;
        l = bright_level();
        vmax = 255 * l / 10;
        c = '0;
        if (q.pos >= PIXEL_COUNT)
            c = '0;
        else if (q.cur)
        begin
            case (sh_cursor_fx)
                CUR_STEADY: c = dim(sh_pr, sh_pg, sh_pb);
                CUR_BLINK: c = ((f / 15) % 2 == 0) ? dim(sh_pr, sh_pg, sh_pb) : '0;
                CUR_BREATHE: c = breathe_colour(wave_at(f * STEP_FRAME_FAST));
                default: c = hsv_colour(int'((f * 3) % 256), 255, vmax);
            endcase
        end
        else if (q.idle && sh_idle_fx >= IDLE_RAINBOW && sh_idle_fx <= IDLE_SLOW_RBW)
        begin
            case (sh_idle_fx)
                IDLE_RAINBOW: c = hsv_colour(int'((f + p * 8) % 256), 255, vmax);
                IDLE_WARM:
                begin
                    w = wave_at(f * STEP_FRAME_FAST + p * STEP_POS_WAVE);
                    v = w * l / 10;
                    c = '{v[7:0], 8'(v * 6 / 10), 8'(v * 2 / 10)};
                end
                IDLE_BREATHE: c = breathe_colour(wave_at(f * STEP_FRAME_SLOW));
                default: c = hsv_colour(int'((f * 2 + p * 6) % 256), 200, vmax);
            endcase
        end
        else if (q.on)
            c = dim(q.r, q.g, q.b);
        return c;
    endfunction

    // Drive one request beat and queue its colour
    task automatic send_pixel(pixel_req_t q, bit known, rgb_t rgb);
        int gap;
        gap = burst_mode ? 0 : (($urandom_range(9) == 0) ? $urandom_range(20, 3)
                                                          : $urandom_range(1));
        // Drop valid only when a gap follows
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        frame_count    <= q.frame;
        pixel_position <= q.pos;
        is_cursor      <= q.cur;
        idle_active    <= q.idle;
        led_on         <= q.on;
        led_red        <= q.r;
        led_green      <= q.g;
        led_blue       <= q.b;
        colour_queue.push_back(known ? rgb : pixel_colour(q));
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    // Drop the request, then wait for the pipe to drain
    task automatic drain();
        in_valid <= 1'b0;
        while (colour_queue.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_BRIGHTNESS: sh_bright    = val[3:0];
            REG_IDLE_FX:    sh_idle_fx   = val[2:0];
            REG_CURSOR_FX:  sh_cursor_fx = val[1:0];
            REG_PRESET_R:   sh_pr        = val;
            REG_PRESET_G:   sh_pg        = val;
            REG_PRESET_B:   sh_pb        = val;
            default: ;
        endcase
    endtask

    function automatic pixel_req_t random_pixel();
        pixel_req_t q;
        q = pixel_req_t'($bits(pixel_req_t)'({$urandom, $urandom}));
        q.cur = ($urandom_range(7) == 0);
        return q;
    endfunction

    // Receiver: random stalls, long hold-off on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (60) @(negedge clk);
                hold_off_req = 1'b0;
            end
            stall = ($urandom_range(3) == 0) ?
                    (($urandom_range(9) == 0) ? $urandom_range(25, 5) : 1) : 0;
            if (burst_mode) stall = 0;
            out_ready <= (stall == 0);
            repeat (stall) @(negedge clk);
            if (stall != 0) out_ready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest expectation
    always @(posedge clk)
    begin
        rgb_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (colour_queue.size() == 0)
            begin
                $error("unexpected output beat");
                errors++;
            end
            else
            begin
                e = colour_queue.pop_front();
                if (out_red !== e.r)
                begin
                    $error("out_red expected %0d actual %0d", e.r, out_red);
                    errors++;
                end
                if (out_green !== e.g)
                begin
                    $error("out_green expected %0d actual %0d", e.g, out_green);
                    errors++;
                end
                if (out_blue !== e.b)
                begin
                    $error("out_blue expected %0d actual %0d", e.b, out_blue);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        pixel_row_t rows[$];
        pixel_req_t q;
        int nn, u, a, d, ph;
        logic [7:0] settings[6][4];
        // Build the sine table independently
        nn = 128;
        for (int k = 0; k < 256; k++)
        begin
            u = k % nn;
            a = u * (nn - u);
            d = 5 * nn * nn - 4 * a;
            wave_tab[k] = (k < nn) ? 8'(128 + 127 * 16 * a / d) : 8'(128 - 128 * 16 * a / d);
        end
        clk = 0; rst_n = 0; errors = 0; cycles = 0;
        stim_done = 0; hold_off_req = 0; burst_mode = 0;
        in_valid = 0; cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        frame_count = '0; pixel_position = '0; is_cursor = 0; idle_active = 0;
        led_on = 0; led_red = '0; led_green = '0; led_blue = '0;
        sh_bright = 5; sh_idle_fx = 0; sh_cursor_fx = 0;
        sh_pr = 255; sh_pg = 255; sh_pb = 255;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // Directed table at reset settings
        rows.push_back('{'{16'd0, 8'd0, 1'b0, 1'b0, 1'b1, 8'd255, 8'd255, 8'd255},
                         1'b1, '{8'd127, 8'd127, 8'd127}});
        rows.push_back('{'{16'hFFFF, 8'd255, 1'b0, 1'b1, 1'b1, 8'd0, 8'd0, 8'd0},
                         1'b1, '{8'd0, 8'd0, 8'd0}});
        rows.push_back('{'{16'd7, 8'd3, 1'b0, 1'b1, 1'b0, 8'd9, 8'd9, 8'd9},
                         1'b1, '{8'd0, 8'd0, 8'd0}});
        rows.push_back('{'{16'd5, 8'd9, 1'b1, 1'b1, 1'b0, 8'd0, 8'd0, 8'd0},
                         1'b1, '{8'd127, 8'd127, 8'd127}});
        rows.push_back('{'{16'd1, 8'd1, 1'b0, 1'b0, 1'b1, 8'd10, 8'd20, 8'd30},
                         1'b1, '{8'd5, 8'd10, 8'd15}});
        foreach (rows[i]) send_pixel(rows[i].req, rows[i].known, rows[i].rgb);
        drain();

        // Every idle and cursor effect, full brightness and overrange
        for (int fx = 0; fx < 8; fx++)
        begin
            write_reg(REG_IDLE_FX, 8'(fx));
            write_reg(REG_CURSOR_FX, 8'(fx % 4));
            write_reg(REG_BRIGHTNESS, (fx == 7) ? 8'd15 : 8'(fx + 4));
            send_pixel('{16'(fx * 15), 8'(fx * 31), 1'b0, 1'b1, 1'b1, 8'hFF, 8'h0, 8'h80},
                       1'b0, '0);
            send_pixel('{16'(fx * 15 + 15), 8'd0, 1'b1, 1'b1, 1'b0, 8'h0, 8'h0, 8'h0},
                       1'b0, '0);
            drain();
        end
        // Out-of-range register index is ignored
        write_reg(3'd7, 8'hAA);
        write_reg(3'd6, 8'h55);

        // Random phases over a sweep of settings, extremes included
        settings = '{'{8'd0, 8'd10, 8'd15, 8'd3}, '{8'd1, 8'd2, 8'd3, 8'd4},
                     '{8'd0, 8'd1, 8'd2, 8'd3}, '{8'd0, 8'd255, 8'd17, 8'd200},
                     '{8'd255, 8'd0, 8'd128, 8'd99}, '{8'd0, 8'd255, 8'd64, 8'd1}};
        for (ph = 0; ph < 12; ph++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(3'(r), (ph < 4) ? settings[r][ph] : 8'($urandom));
            if (ph == 3)
            begin
                hold_off_req = 1'b1;
                burst_mode = 1'b1;
            end
            for (int n = 0; n < 150; n++)
            begin
                q = random_pixel();
                send_pixel(q, 1'b0, '0);
            end
            burst_mode = 1'b0;
            drain();
        end

        stim_done = 1;
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
